[hdl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants for the section address translator
// Request, response, table entry and chain token types, opcodes and class codes.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int MAX_SECTIONS = 16;
   localparam int SEC_ID_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CMP_W = (SEC_ID_W > 4) ? SEC_ID_W : 4;
   localparam int CNT_W = ($clog2(MAX_SECTIONS + 1) > 5) ? $clog2(MAX_SECTIONS + 1) : 5;

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_TRANSLATE = 2'd1;
   localparam logic [1:0] OP_CLASSIFY  = 2'd2;

   localparam logic [1:0] REGION_OUTSIDE = 2'd0;
   localparam logic [1:0] REGION_RAW     = 2'd1;
   localparam logic [1:0] REGION_VIRTUAL = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  entry_index;
      logic [31:0] entry_virtual_base;
      logic [31:0] entry_virtual_length;
      logic [31:0] entry_file_pointer;
      logic [31:0] entry_file_length;
      logic [31:0] query_address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] file_offset;
      logic [3:0]  hit_index;
      logic [1:0]  region_class;
   } rsp_type;

   typedef struct packed {
      logic [31:0] virtual_base;
      logic [31:0] virtual_length;
      logic [31:0] file_pointer;
      logic [31:0] file_length;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  opcode;
      logic [3:0]  entry_index;
      logic [31:0] query_address;
      rsp_type     rsp;
   } token_type;

endpackage

[hdl/sat_cell.sv]
// ----------------------------------------------------------------------------
// sat_cell: one section entry of the translator chain
// Holds one table entry, tests the passing request token against it and
// hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module sat_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [sat_pkg::SEC_ID_W-1:0]     entry_id,
   input  logic                             in_use,
   input  logic                             wr_en,
   input  sat_pkg::entry_type               wr_entry,
   input  sat_pkg::token_type               tok_in,
   output sat_pkg::token_type               tok_out
);
   import sat_pkg::*;

   entry_type   entry_ff;
   token_type   tok_ff;
   token_type   tok_next_in;
   logic [31:0] span_offset;
   logic        above_base;
   logic        in_span;
   logic [CMP_W-1:0] id_ext;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   assign id_ext      = CMP_W'(entry_id);
   assign span_offset = tok_in.query_address - entry_ff.virtual_base;
   assign above_base  = tok_in.query_address >= entry_ff.virtual_base;
   assign in_span     = above_base && (span_offset < entry_ff.virtual_length);

   always_comb begin
      tok_next_in = tok_in;
      case (tok_in.opcode)
         OP_TRANSLATE: begin
            // first usable section wins; later cells leave a found token alone
            if (!tok_in.rsp.hit && in_use && (entry_ff.file_length != 32'd0) && in_span) begin
               tok_next_in.rsp.hit         = 1'b1;
               tok_next_in.rsp.file_offset = entry_ff.file_pointer + span_offset;
               tok_next_in.rsp.hit_index   = id_ext[3:0];
            end
         end
         OP_CLASSIFY: begin
            if (CMP_W'(tok_in.entry_index) == id_ext) begin
               if (!in_use || !above_base) begin
                  tok_next_in.rsp.region_class = REGION_OUTSIDE;
               end else if (span_offset <= entry_ff.file_length) begin
                  tok_next_in.rsp.region_class = REGION_RAW;
               end else if (span_offset < entry_ff.virtual_length) begin
                  tok_next_in.rsp.region_class = REGION_VIRTUAL;
               end else begin
                  tok_next_in.rsp.region_class = REGION_OUTSIDE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

[hdl/section_address_translator.sv]
// ----------------------------------------------------------------------------
// section_address_translator: section table lookup for image address mapping
// Loads section entries, translates virtual addresses to file offsets and
// classifies an address against one section.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with a req_type payload; each one
//   produces exactly one response on rsp_valid/rsp_ready. csr_write_enable
//   writes section_count; write it only while idle.
//   A request enters a chain of MAX_SECTIONS cells, one entry per cell, and
//   moves one cell per cycle while the chain is not held; rsp_valid rises
//   when it leaves the last cell for the output register. One request is in
//   the chain at a time: the next one is taken the cycle after the previous
//   one reaches the output register, and not before.
//   A load writes its entry at acceptance and answers all zeros.
//   Reset clears section_count and all valid flags; table contents stay
//   undefined until loaded. If the receiver stalls with a response waiting
//   and the next request reaches the chain end, the chain holds until the
//   response is taken.
// ----------------------------------------------------------------------------
module section_address_translator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sat_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sat_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [4:0]        csr_write_data
);
   import sat_pkg::*;

   logic [4:0]       count_ff;
   logic             busy_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             req_accept;
   logic             advance;
   entry_type        wr_entry;
   token_type        chain_tok [MAX_SECTIONS+1];
   logic [MAX_SECTIONS-1:0] chain_valid;
   token_type        last_tok;

   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && req_ready;
   assign last_tok   = chain_tok[MAX_SECTIONS];
   // hold the chain only when its last token cannot leave
   assign advance    = !(last_tok.valid && rsp_valid_ff && !rsp_ready);

   assign wr_entry.virtual_base   = req_data.entry_virtual_base;
   assign wr_entry.virtual_length = req_data.entry_virtual_length;
   assign wr_entry.file_pointer   = req_data.entry_file_pointer;
   assign wr_entry.file_length    = req_data.entry_file_length;

   always_comb begin
      chain_tok[0].valid         = req_accept;
      chain_tok[0].opcode        = req_data.opcode;
      chain_tok[0].entry_index   = req_data.entry_index;
      chain_tok[0].query_address = req_data.query_address;
      chain_tok[0].rsp           = '0;
   end

   for (genvar gi = 0; gi < MAX_SECTIONS; gi++) begin : g_cell
      logic in_use;
      logic wr_en;

      assign in_use = CNT_W'(gi) < CNT_W'(count_ff);
      assign wr_en  = req_accept && (req_data.opcode == OP_LOAD) &&
                      (CMP_W'(req_data.entry_index) == CMP_W'(gi));
      assign chain_valid[gi] = chain_tok[gi+1].valid;

      sat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .entry_id (SEC_ID_W'(gi)),
         .in_use   (in_use),
         .wr_en    (wr_en),
         .wr_entry (wr_entry),
         .tok_in   (chain_tok[gi]),
         .tok_out  (chain_tok[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_accept) begin
         busy_ff <= 1'b1;
      end else if (last_tok.valid && advance) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_tok.valid && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_tok.valid && advance) begin
         rsp_data_ff <= last_tok.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) <= 1)
      else $error("more than one request in the cell chain");

   a_enter_chain: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> chain_valid[0])
      else $error("accepted request did not enter the first cell");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (chain_valid == '0))
      else $error("chain holds a request while idle");

   a_hit_no_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.region_class == REGION_OUTSIDE))
      else $error("translate hit carries a region class");
`endif

endmodule

[dv/section_address_translator_tb.sv]
// ----------------------------------------------------------------------------
// section_address_translator_tb: self-checking bench for the section table
// Drives load, translate, classify and unused-opcode requests with random
// idle gaps on both channels and walks section_count through its range. Each
// request is predicted at acceptance, each response compared field by field.
// ----------------------------------------------------------------------------
module section_address_translator_tb;
   import sat_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1280;
   localparam int PHASES        = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 2 * (MAX_SECTIONS + 1) + 8;
   localparam int CYCLE_LIMIT   = 400000;

   // Predicts each response from a private copy of the section table.
   class section_map_book;
      entry_type  sections[MAX_SECTIONS];
      logic [4:0] section_count;
      rsp_type    awaited[$];
      int         mismatches;

      function new();
         foreach (sections[i]) sections[i] = '0;
         section_count = '0;
         mismatches = 0;
      endfunction

      function void set_count(logic [4:0] value);
         section_count = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function rsp_type answer_for(req_type r);
         rsp_type     a;
         int          in_use;
         logic [31:0] span_offset;
         a = '0;
         in_use = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
         case (r.opcode)
            OP_LOAD: begin
               if (r.entry_index < MAX_SECTIONS) begin
                  sections[r.entry_index].virtual_base   = r.entry_virtual_base;
                  sections[r.entry_index].virtual_length = r.entry_virtual_length;
                  sections[r.entry_index].file_pointer   = r.entry_file_pointer;
                  sections[r.entry_index].file_length    = r.entry_file_length;
               end
            end
            OP_TRANSLATE: begin
               // first match in index order wins
               for (int i = 0; i < in_use; i++) begin
                  span_offset = r.query_address - sections[i].virtual_base;
                  if (!a.hit && sections[i].file_length != 0 &&
                      r.query_address >= sections[i].virtual_base &&
                      span_offset < sections[i].virtual_length) begin
                     a.hit = 1'b1;
                     a.file_offset = sections[i].file_pointer + span_offset;
                     a.hit_index = 4'(i);
                  end
               end
            end
            OP_CLASSIFY: begin
               if (r.entry_index < in_use &&
                   r.query_address >= sections[r.entry_index].virtual_base) begin
                  span_offset = r.query_address - sections[r.entry_index].virtual_base;
                  // raw end bound is inclusive
                  if (span_offset <= sections[r.entry_index].file_length)
                     a.region_class = REGION_RAW;
                  else if (span_offset < sections[r.entry_index].virtual_length)
                     a.region_class = REGION_VIRTUAL;
                  else
                     a.region_class = REGION_OUTSIDE;
               end
            end
            default: ;
         endcase
         return a;
      endfunction

      function void note_request(req_type r);
         awaited.push_back(answer_for(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: hit %0d offset %h index %0d class %0d",
                        got.hit, got.file_offset, got.hit_index, got.region_class);
            return;
         end
         want = awaited.pop_front();
         if (got.hit !== want.hit || got.file_offset !== want.file_offset ||
             got.hit_index !== want.hit_index || got.region_class !== want.region_class) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response mismatch: expected hit %0d offset %h index %0d class %0d",
                        want.hit, want.file_offset, want.hit_index, want.region_class);
               $display("                   got      hit %0d offset %h index %0d class %0d",
                        got.hit, got.file_offset, got.hit_index, got.region_class);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write_enable;
   logic [4:0]  csr_write_data;

   section_map_book book;
   int          cycle_count;
   int          stall_left;
   int          hold_off_left;
   int          sender_idle_odds;
   int          receiver_idle_odds;

   section_address_translator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("section_address_translator regression: fail");
         $finish;
      end
   end

   // Receiver: long hold-off first, then short random stalls.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idle_odds != 0 && $urandom_range(1, receiver_idle_odds) == 1) begin
         stall_left = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_data);
   end

   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return $urandom_range(1, 16);
         2, 3:    return $urandom_range(1, 32'h4000);
         4:       return $urandom;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1, 2:    return 32'h1000 * $urandom_range(0, 64);
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h3000);
         default: return 32'd0;
      endcase
   endfunction

   function automatic req_type load_request(logic [3:0] idx, logic [31:0] vbase,
                                            logic [31:0] vlen, logic [31:0] fptr,
                                            logic [31:0] flen);
      req_type r;
      r.opcode = OP_LOAD;
      r.entry_index = idx;
      r.entry_virtual_base = vbase;
      r.entry_virtual_length = vlen;
      r.entry_file_pointer = fptr;
      r.entry_file_length = flen;
      r.query_address = $urandom;
      return r;
   endfunction

   function automatic req_type random_load(logic [3:0] idx);
      logic [31:0] vlen;
      logic [31:0] flen;
      vlen = pick_length();
      flen = ($urandom_range(0, 3) == 0) ? vlen : pick_length();
      return load_request(idx, pick_base(), vlen, $urandom, flen);
   endfunction

   // Entry fields ride along as noise on queries.
   function automatic req_type query_request(logic [1:0] op, logic [3:0] idx,
                                             logic [31:0] addr);
      req_type r;
      r.opcode = op;
      r.entry_index = idx;
      r.entry_virtual_base = $urandom;
      r.entry_virtual_length = $urandom;
      r.entry_file_pointer = $urandom;
      r.entry_file_length = $urandom;
      r.query_address = addr;
      return r;
   endfunction

   function automatic logic [31:0] address_near(entry_type e);
      case ($urandom_range(0, 9))
         0:       return e.virtual_base;
         1:       return e.virtual_base - 1;
         2:       return e.virtual_base + e.file_length;
         3:       return e.virtual_base + e.file_length + 1;
         4:       return e.virtual_base + e.virtual_length - 1;
         5:       return e.virtual_base + e.virtual_length;
         6, 7:    return e.virtual_base + ((e.virtual_length == 0) ? 32'd0 :
                                           $urandom % e.virtual_length);
         8:       return e.virtual_base + $urandom_range(0, 32'h100);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      int         roll;
      logic [3:0] idx;
      req_type    r;
      roll = $urandom_range(0, 99);
      idx = 4'($urandom_range(0, MAX_SECTIONS - 1));
      if (roll < 22) begin
         r = random_load(idx);
      end else if (roll < 60) begin
         r = query_request(OP_TRANSLATE, 4'($urandom), address_near(book.sections[idx]));
      end else if (roll < 85) begin
         r = query_request(OP_CLASSIFY, idx, address_near(book.sections[idx]));
      end else if (roll < 95) begin
         r = query_request(OP_TRANSLATE, 4'($urandom), $urandom);
      end else begin
         r = query_request(OP_UNUSED, 4'($urandom), $urandom);
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      @(negedge clock);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      book.note_request(r);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic issue(input req_type r);
      if (sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1)
         pause_sender($urandom_range(1, 5));
      send_request(r);
   endtask

   // Write only with nothing in flight; drop valid before draining.
   task automatic write_section_count(input logic [4:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      book.set_count(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [4:0] phase_counts[PHASES];
      req_type    all_ones;
      book = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      cycle_count = 0;
      stall_left = 0;
      hold_off_left = 0;
      sender_idle_odds = 4;
      receiver_idle_odds = 6;
      phase_counts = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd9, 5'd5, 5'd16};
      phase_counts[6] = 5'($urandom_range(2, 15));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: nothing is in use, so no entry is read.
      issue(query_request(OP_TRANSLATE, 4'd0, 32'h0));
      issue(query_request(OP_CLASSIFY, 4'd15, 32'hFFFF_FFFF));
      all_ones = '1;
      issue(all_ones);

      issue(load_request(4'd0, 32'h1000, 32'h2000, 32'h400, 32'h800));
      issue(load_request(4'd1, 32'h1800, 32'h1000, 32'h10000, 32'h1000));
      issue(load_request(4'd2, 32'h5000, 32'h1000, 32'h0, 32'h0));
      issue(load_request(4'd3, 32'h5000, 32'h1000, 32'h9000, 32'h200));
      issue(load_request(4'd4, 32'h8000, 32'h0, 32'h100, 32'h100));
      issue(load_request(4'd5, 32'hFFFF_F000, 32'h1000, 32'hFFFF_FF00, 32'h1000));
      for (int i = 6; i < MAX_SECTIONS - 1; i++)
         issue(random_load(4'(i)));
      issue(load_request(4'd15, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

      write_section_count(5'd16);
      // overlap: entry 0 shadows entry 1
      issue(query_request(OP_TRANSLATE, 4'd0, 32'h1900));
      // zero raw size: entry 2 is skipped in favor of entry 3
      issue(query_request(OP_TRANSLATE, 4'd0, 32'h5100));
      // offset wraps past 2^32
      issue(query_request(OP_TRANSLATE, 4'd0, 32'hFFFF_FFFF));
      issue(query_request(OP_CLASSIFY, 4'd0, 32'h1800));
      issue(query_request(OP_CLASSIFY, 4'd0, 32'h1801));
      issue(query_request(OP_CLASSIFY, 4'd0, 32'h0FFF));
      issue(query_request(OP_CLASSIFY, 4'd0, 32'h3000));
      issue(query_request(OP_CLASSIFY, 4'd4, 32'h8000));

      for (int p = 0; p < PHASES; p++) begin
         write_section_count(phase_counts[p]);
         sender_idle_odds = (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(2, 6);
         receiver_idle_odds = (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(2, 6);
         for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
            // stall the receiver long enough to back up the input
            if (p == 1 && k == 20)
               hold_off_left = 300;
            issue(random_request());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0)
         $display("section_address_translator regression: pass");
      else
         $display("section_address_translator regression: fail");
      $finish;
   end

endmodule

[filelist.f]
hdl/sat_pkg.sv
hdl/sat_cell.sv
hdl/section_address_translator.sv
dv/section_address_translator_tb.sv
